/* src/sslm_pkg.sv */
`default_nettype none
package sslm_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int PTR_W        = $clog2(BUFFER_DEPTH + 1);

  localparam int POS_W    = 20;
  localparam int FLAGS_W  = 8;
  localparam int WEIGHT_W = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_MERGE  = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [POS_W-1:0]    start_pos;
    logic [POS_W-1:0]    end_pos;
    logic [FLAGS_W-1:0]  flags;
    logic [WEIGHT_W-1:0] weight;
  } span_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_EMIT2 = 4'b1000
  } state_t;

endpackage
`default_nettype wire

/* src/sorted_span_list_merger_unit.sv */
`default_nettype none
// Merges a buffered list of spans with a stream of incoming spans, both
// sorted by start. Load requests (opcode 0) fill the span buffer; a load into
// a full buffer is dropped and sets the sticky overflow flag. A merge request
// (opcode 1) emits the buffered spans that start before the incoming span,
// then the incoming span, with an extra emit state when a buffered span and
// the incoming span share a start and differ in end. A finish request
// (opcode 2) emits the spans still buffered, or the empty marker if none,
// and then empties the buffer. Each buffered span passes a fetch and a compare
// state, as the single registered read port of the span buffer feeds one
// shared compare and saturating add unit. Results leave through a single
// output register, so the next request is taken while the last result waits.
module sorted_span_list_merger_unit (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [1:0]                    in_opcode,
  input  wire  [sslm_pkg::POS_W-1:0]    in_span_start,
  input  wire  [sslm_pkg::POS_W-1:0]    in_span_end,
  input  wire  [sslm_pkg::FLAGS_W-1:0]  in_span_flags,
  input  wire  [sslm_pkg::WEIGHT_W-1:0] in_span_weight,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [sslm_pkg::POS_W-1:0]    out_start,
  output logic [sslm_pkg::POS_W-1:0]    out_end,
  output logic [sslm_pkg::FLAGS_W-1:0]  out_flags,
  output logic [sslm_pkg::WEIGHT_W-1:0] out_weight,
  output logic                          out_out_valid,
  output logic                          out_out_last,
  output logic                          out_overflow
);
  import sslm_pkg::*;

  span_t mem [BUFFER_DEPTH];
  span_t rd_data_r;

  state_t state_r, state_nxt;
  opcode_t op_r;
  span_t req_r;
  logic [PTR_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic ovf_r, ovf_nxt;
  logic sec_buf_r, sec_buf_nxt;

  logic ovld_r, ovld_nxt;
  span_t res_r;
  logic res_span_r, res_last_r, res_ovf_r;

  logic emit;
  span_t emit_span;
  logic emit_is_span, emit_last;

  logic accept, do_load, slot_free, avail, last_entry;
  logic start_lt, start_eq, end_lt, end_gt;
  logic [WEIGHT_W:0] wsum;
  logic [WEIGHT_W-1:0] wsat;
  span_t incoming, combined;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign do_load   = accept && (opcode_t'(in_opcode) == OP_LOAD) && (fill_r < PTR_W'(BUFFER_DEPTH));
  assign slot_free = !ovld_r || out_ready;
  assign avail     = rd_ptr_r < fill_r;
  assign last_entry = (rd_ptr_r + PTR_W'(1)) == fill_r;

  assign start_lt = rd_data_r.start_pos < req_r.start_pos;
  assign start_eq = rd_data_r.start_pos == req_r.start_pos;
  assign end_lt   = rd_data_r.end_pos < req_r.end_pos;
  assign end_gt   = rd_data_r.end_pos > req_r.end_pos;
  assign wsum     = {1'b0, rd_data_r.weight} + {1'b0, req_r.weight};
  assign wsat     = wsum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : wsum[WEIGHT_W-1:0];

  assign incoming = req_r;
  always_comb begin
    combined        = req_r;
    combined.flags  = rd_data_r.flags;
    combined.weight = wsat;
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    rd_ptr_nxt   = rd_ptr_r;
    ovf_nxt      = ovf_r;
    sec_buf_nxt  = sec_buf_r;
    emit         = 1'b0;
    emit_span    = rd_data_r;
    emit_is_span = 1'b1;
    emit_last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_t'(in_opcode))
            OP_LOAD: begin
              if (fill_r < PTR_W'(BUFFER_DEPTH)) begin
                fill_nxt = fill_r + PTR_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_MERGE, OP_FINISH: state_nxt = ST_FETCH;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: state_nxt = ST_CMP;
      ST_CMP: begin
        if (slot_free) begin
          emit = 1'b1;
          if (op_r == OP_FINISH) begin
            if (avail) begin
              emit_last  = last_entry;
              rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
              state_nxt  = last_entry ? ST_IDLE : ST_FETCH;
              if (last_entry) begin
                fill_nxt   = '0;
                rd_ptr_nxt = '0;
              end
            end else begin
              emit_span    = '0;
              emit_is_span = 1'b0;
              emit_last    = 1'b1;
              fill_nxt     = '0;
              rd_ptr_nxt   = '0;
              state_nxt    = ST_IDLE;
            end
          end else if (avail && start_lt) begin
            rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
            state_nxt  = ST_FETCH;
          end else if (avail && start_eq) begin
            rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
            if (end_lt) begin
              sec_buf_nxt = 1'b0;
              state_nxt   = ST_EMIT2;
            end else if (end_gt) begin
              emit_span   = incoming;
              sec_buf_nxt = 1'b1;
              state_nxt   = ST_EMIT2;
            end else begin
              emit_span = combined;
              state_nxt = ST_IDLE;
            end
          end else begin
            emit_span = incoming;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT2: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_span = sec_buf_r ? rd_data_r : incoming;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end
    if (emit) begin
      ovld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[fill_r[ADDR_W-1:0]] <= '{in_span_start, in_span_end, in_span_flags, in_span_weight};
    end
    if (state_r == ST_FETCH) begin
      rd_data_r <= mem[rd_ptr_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= opcode_t'(in_opcode);
      req_r <= '{in_span_start, in_span_end, in_span_flags, in_span_weight};
    end
    if (emit) begin
      res_r      <= emit_span;
      res_span_r <= emit_is_span;
      res_last_r <= emit_last;
      res_ovf_r  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      rd_ptr_r  <= '0;
      ovf_r     <= 1'b0;
      sec_buf_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      ovf_r     <= ovf_nxt;
      sec_buf_r <= sec_buf_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  assign out_valid     = ovld_r;
  assign out_start     = res_r.start_pos;
  assign out_end       = res_r.end_pos;
  assign out_flags     = res_r.flags;
  assign out_weight    = res_r.weight;
  assign out_out_valid = res_span_r;
  assign out_out_last  = res_last_r;
  assign out_overflow  = res_ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= PTR_W'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ptr_r <= fill_r)
    else $error("read pointer passed fill count");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && !res_span_r |-> res_last_r)
    else $error("empty marker without last");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit && emit_last |=> (fill_r == '0) && (rd_ptr_r == '0))
    else $error("finish left buffer occupied");

endmodule
`default_nettype wire

/* verif/sorted_span_list_merger_unit_test.sv */
`timescale 1ns / 100ps

module sorted_span_list_merger_unit_test;
  import sslm_pkg::*;

  localparam int RANDOM_ITEMS   = 100;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    span_t sp;
    logic  has_span;
    logic  is_last;
    logic  ovf;
  } merged_out_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  opcode_t             in_opcode;
  logic [POS_W-1:0]    in_span_start;
  logic [POS_W-1:0]    in_span_end;
  logic [FLAGS_W-1:0]  in_span_flags;
  logic [WEIGHT_W-1:0] in_span_weight;
  logic                out_valid;
  logic                out_ready;
  logic [POS_W-1:0]    out_start;
  logic [POS_W-1:0]    out_end;
  logic [FLAGS_W-1:0]  out_flags;
  logic [WEIGHT_W-1:0] out_weight;
  logic                out_out_valid;
  logic                out_out_last;
  logic                out_overflow;

  span_t       span_list [BUFFER_DEPTH];
  int          span_fill = 0;
  int          span_rd = 0;
  logic        overflow_sticky = 1'b0;
  merged_out_t merged_q[$];

  int fail_count = 0;
  int burst_left = 16;
  int hold_off_cycles = 0;
  int idle_cycles = 0;
  int n_loads = 0, n_dropped = 0, n_merges = 0, n_finishes = 0;
  int n_results = 0, n_combined = 0, n_saturated = 0, n_markers = 0;

  sorted_span_list_merger_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_span_start  (in_span_start),
    .in_span_end    (in_span_end),
    .in_span_flags  (in_span_flags),
    .in_span_weight (in_span_weight),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_start      (out_start),
    .out_end        (out_end),
    .out_flags      (out_flags),
    .out_weight     (out_weight),
    .out_out_valid  (out_out_valid),
    .out_out_last   (out_out_last),
    .out_overflow   (out_overflow)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic span_t span_of(logic [POS_W-1:0] s, logic [POS_W-1:0] e,
                                    logic [FLAGS_W-1:0] f, logic [WEIGHT_W-1:0] w);
    span_t sp;
    sp.start_pos = s;
    sp.end_pos = e;
    sp.flags = f;
    sp.weight = w;
    return sp;
  endfunction

  function automatic logic [POS_W-1:0] step_pos(logic [POS_W-1:0] p, int unsigned d);
    logic [POS_W:0] t;
    t = {1'b0, p} + (POS_W+1)'(d);
    return t[POS_W] ? '1 : t[POS_W-1:0];
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    if ($urandom_range(0, 4) == 0) return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
    return $urandom();
  endfunction

  function automatic span_t random_span_at(logic [POS_W-1:0] s);
    return span_of(s, step_pos(s, $urandom_range(0, 2)), FLAGS_W'($urandom_range(0, 255)),
                   pick_weight());
  endfunction

  function automatic void push_merged(span_t sp, logic has_span, logic is_last);
    merged_out_t r;
    r.sp = sp;
    r.has_span = has_span;
    r.is_last = is_last;
    r.ovf = overflow_sticky;
    merged_q.push_back(r);
  endfunction

  function automatic void merge_span_request(opcode_t op, span_t sp);
    span_t           head;
    logic [WEIGHT_W:0] sum;
    case (op)
      OP_LOAD: begin
        n_loads++;
        if (span_fill >= BUFFER_DEPTH) begin
          overflow_sticky = 1'b1;
          n_dropped++;
        end else begin
          span_list[span_fill] = sp;
          span_fill++;
        end
      end
      OP_MERGE: begin
        n_merges++;
        while (span_rd < span_fill && span_list[span_rd].start_pos < sp.start_pos) begin
          push_merged(span_list[span_rd], 1'b1, 1'b0);
          span_rd++;
        end
        if (span_rd < span_fill && span_list[span_rd].start_pos == sp.start_pos) begin
          head = span_list[span_rd];
          if (head.end_pos < sp.end_pos) begin
            push_merged(head, 1'b1, 1'b0);
            push_merged(sp, 1'b1, 1'b0);
          end else if (head.end_pos > sp.end_pos) begin
            push_merged(sp, 1'b1, 1'b0);
            push_merged(head, 1'b1, 1'b0);
          end else begin
            sum = {1'b0, head.weight} + {1'b0, sp.weight};
            n_combined++;
            if (sum[WEIGHT_W]) n_saturated++;
            head.weight = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
            push_merged(head, 1'b1, 1'b0);
          end
          span_rd++;
        end else begin
          push_merged(sp, 1'b1, 1'b0);
        end
      end
      OP_FINISH: begin
        n_finishes++;
        if (span_rd >= span_fill) begin
          n_markers++;
          push_merged('0, 1'b0, 1'b1);
        end else begin
          for (int i = span_rd; i < span_fill; i++)
            push_merged(span_list[i], 1'b1, i == span_fill - 1);
        end
        span_fill = 0;
        span_rd = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input opcode_t op, input span_t sp);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_span_start <= sp.start_pos;
    in_span_end <= sp.end_pos;
    in_span_flags <= sp.flags;
    in_span_weight <= sp.weight;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    merge_span_request(op, sp);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic test_directed_cases();
    send_request(OP_FINISH, '0);
    send_request(OP_NONE, span_of('1, '1, '1, '1));
    send_request(OP_LOAD, span_of(0, 0, 8'h00, 32'h0000_0000));
    send_request(OP_LOAD, span_of(5, 10, 8'hA5, 32'hFFFF_0000));
    send_request(OP_LOAD, span_of(5, 20, 8'h5A, 32'h0000_0001));
    send_request(OP_LOAD, span_of(9, 9, 8'hFF, 32'd100));
    send_request(OP_LOAD, span_of('1, '1, 8'hFF, 32'hFFFF_FFFF));
    send_request(OP_MERGE, span_of(0, 0, 8'h3C, 32'd7));
    send_request(OP_MERGE, span_of(5, 15, 8'h11, 32'd2));
    send_request(OP_MERGE, span_of(5, 15, 8'h22, 32'd3));
    send_request(OP_MERGE, span_of(20'hFFFFE, 0, 8'h44, 32'h1234_5678));
    send_request(OP_MERGE, span_of('1, '1, 8'h00, 32'h0001_0000));
    send_request(OP_MERGE, span_of(3, 3, 8'h81, 32'd9));
    send_request(OP_LOAD, span_of(1, 2, 8'h7E, 32'hDEAD_BEEF));
    send_request(OP_FINISH, '0);
    send_request(OP_LOAD, span_of(100, 50, 8'h01, 32'd1));
    send_request(OP_LOAD, span_of(50, 60, 8'h02, 32'd2));
    send_request(OP_MERGE, span_of(60, 70, 8'h03, 32'd3));
    send_request(OP_FINISH, '0);
    send_request(OP_MERGE, span_of(7, 7, 8'hC3, 32'd5));
    send_request(OP_FINISH, '0);
    send_request(OP_LOAD, span_of(200, 300, 8'h99, 32'h8000_0000));
    send_request(OP_MERGE, span_of(200, 300, 8'h66, 32'h7FFF_FFFF));
    send_request(OP_MERGE, span_of(200, 300, 8'h55, 32'd4));
    send_request(OP_FINISH, '0);
  endtask

  task automatic test_random_merges();
    int               sent;
    int               n_ld;
    int               n_mg;
    int               loaded;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] pos;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n_ld = ($urandom_range(0, 9) == 0) ? $urandom_range(9, BUFFER_DEPTH) : $urandom_range(0, 8);
      n_mg = $urandom_range(0, 8);
      base = POS_W'($urandom_range(0, 20'hFFFFF));
      loaded = 0;
      pos = base;
      for (int k = 0; k < n_ld; k++) begin
        pos = step_pos(pos, $urandom_range(0, 3));
        send_request(OP_LOAD, random_span_at(pos));
        loaded++;
        sent++;
      end
      pos = base;
      for (int k = 0; k < n_mg; k++) begin
        pos = step_pos(pos, $urandom_range(0, 3));
        send_request(OP_MERGE, random_span_at(pos));
        sent++;
        if ($urandom_range(0, 19) == 0)
          send_request(OP_NONE, span_of(POS_W'($urandom_range(0, 20'hFFFFF)),
                                        POS_W'($urandom_range(0, 20'hFFFFF)),
                                        FLAGS_W'($urandom_range(0, 255)), $urandom()));
        if ($urandom_range(0, 19) == 0) begin
          send_request(OP_MERGE, random_span_at(POS_W'($urandom_range(0, 20'hFFFFF))));
          sent++;
        end
        if ($urandom_range(0, 24) == 0 && loaded < BUFFER_DEPTH) begin
          send_request(OP_LOAD, random_span_at(step_pos(pos, $urandom_range(0, 3))));
          loaded++;
          sent++;
        end
      end
      send_request(OP_FINISH, random_span_at(POS_W'($urandom_range(0, 20'hFFFFF))));
      sent++;
    end
  endtask

  task automatic test_full_buffer_backpressure();
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] base;
    hold_off_cycles <= LONG_HOLD;
    base = POS_W'($urandom_range(0, 20'h7FFFF));
    pos = base;
    for (int k = 0; k < BUFFER_DEPTH + 3; k++) begin
      pos = step_pos(pos, $urandom_range(0, 2));
      send_request(OP_LOAD, random_span_at(pos));
    end
    pos = base;
    for (int k = 0; k < 12; k++) begin
      pos = step_pos(pos, $urandom_range(0, 3));
      send_request(OP_MERGE, random_span_at(pos));
    end
    send_request(OP_FINISH, '0);
    send_request(OP_FINISH, '0);
  endtask

  initial begin : receiver
    int ready_mode;
    int ready_phase;
    ready_mode = 0;
    ready_phase = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        if (ready_phase == 0) ready_mode = $urandom_range(0, 3);
        ready_phase = (ready_phase + 1) % 64;
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) < 6);
          2: out_ready <= ((ready_phase % 5) < 3);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    merged_out_t want;
    merged_out_t got;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      got.sp = span_of(out_start, out_end, out_flags, out_weight);
      got.has_span = out_out_valid;
      got.is_last = out_out_last;
      got.ovf = out_overflow;
      if (merged_q.size() == 0) begin
        note_failure($sformatf("unexpected result: start %h end %h flags %h weight %h",
                               out_start, out_end, out_flags, out_weight));
      end else begin
        want = merged_q.pop_front();
        if (got !== want)
          note_failure($sformatf({"result %0d mismatch: expected start %h end %h flags %h ",
                                  "weight %h valid %b last %b ovf %b, got start %h end %h ",
                                  "flags %h weight %h valid %b last %b ovf %b"},
                                 n_results, want.sp.start_pos, want.sp.end_pos,
                                 want.sp.flags, want.sp.weight, want.has_span,
                                 want.is_last, want.ovf, got.sp.start_pos, got.sp.end_pos,
                                 got.sp.flags, got.sp.weight, got.has_span, got.is_last,
                                 got.ovf));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("sorted_span_list_merger_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_NONE;
    in_span_start <= '0;
    in_span_end <= '0;
    in_span_flags <= '0;
    in_span_weight <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_merges();
    test_full_buffer_backpressure();
    in_valid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (merged_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", merged_q.size()));
    $display("covered %0d loads (%0d dropped on a full buffer), %0d merges, %0d finishes",
             n_loads, n_dropped, n_merges, n_finishes);
    $display("checked %0d results: %0d duplicates combined, %0d sums saturated, %0d markers",
             n_results, n_combined, n_saturated, n_markers);
    if (fail_count == 0) begin
      $display("sorted_span_list_merger_unit regression: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("sorted_span_list_merger_unit regression: fail");
    end
    $finish;
  end

endmodule

/* sorted_span_list_merger_unit.f */
src/sslm_pkg.sv
src/sorted_span_list_merger_unit.sv
verif/sorted_span_list_merger_unit_test.sv
